// ===== sv/fpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpcc_pkg: shared definitions for the fan PI cooling controller
// Field widths, fixed-point constants, register indexes and the result type.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  // Field widths.
  localparam int unsigned TargetW   = 8;
  localparam int unsigned MeasW     = 12;
  localparam int unsigned GainW     = 8;
  localparam int unsigned DutyW     = 10;
  localparam int unsigned ErrW      = 14;
  localparam int unsigned SumW      = 16;
  localparam int unsigned PropProdW = ErrW + GainW + 1;
  localparam int unsigned IntProdW  = SumW + GainW + 1;
  localparam int unsigned AccW      = IntProdW + 1;
  localparam int unsigned CtlW      = AccW - 4;

  // Integral sum limits, in 1/16 degree.
  localparam logic signed [SumW-1:0] SumReset  = -16'sd8000;
  localparam logic signed [SumW-1:0] SumForced = -16'sd800;
  localparam logic signed [SumW-1:0] SumMax    = 16'sd16000;
  localparam logic signed [SumW-1:0] SumMin    = -16'sd16000;

  // Controller output limits.
  localparam logic signed [CtlW-1:0] OutMax  = 22'sd1000;
  localparam logic signed [CtlW-1:0] OutLow  = -22'sd1000;
  localparam logic [DutyW-1:0]       LowDuty  = 10'd998;
  localparam logic [DutyW-1:0]       IdleDuty = 10'd50;

  // Gain reset values.
  localparam logic [GainW-1:0] PropGainReset = 8'd30;
  localparam logic [GainW-1:0] IntGainReset  = 8'd1;

  // Configuration register indexes.
  localparam logic CfgPropGain = 1'b0;
  localparam logic CfgIntGain  = 1'b1;

  // One fan command.
  typedef struct packed {
    logic [DutyW-1:0] fan_duty;
    logic             cooling_active;
  } result_t;

endpackage

// ===== sv/fpcc_shape.sv =====
// ----------------------------------------------------------------------------
// fpcc_shape: output shaping of the PI controller
// Sums the two products, divides by 16 toward zero, saturates and maps the
// controller output onto a fan duty and a cooling flag.
// ----------------------------------------------------------------------------
module fpcc_shape (
  input  logic signed [fpcc_pkg::PropProdW-1:0] prop_prod,
  input  logic signed [fpcc_pkg::IntProdW-1:0]  int_prod,
  output fpcc_pkg::result_t                     result
);

  logic signed [fpcc_pkg::AccW-1:0] acc;
  logic signed [fpcc_pkg::AccW-1:0] acc_biased;
  logic signed [fpcc_pkg::CtlW-1:0] ctl;
  logic signed [fpcc_pkg::CtlW-1:0] ctl_neg;

  assign acc = fpcc_pkg::AccW'(prop_prod) + fpcc_pkg::AccW'(int_prod);
  // Adding 15 to negative values makes the arithmetic shift truncate toward zero.
  assign acc_biased = acc + (acc[fpcc_pkg::AccW-1] ? fpcc_pkg::AccW'(15) : '0);
  assign ctl     = fpcc_pkg::CtlW'(acc_biased >>> 4);
  assign ctl_neg = -ctl;

  always_comb begin
    if (ctl >= fpcc_pkg::OutMax) begin
      result.fan_duty       = fpcc_pkg::IdleDuty;
      result.cooling_active = 1'b0;
    end else if (ctl <= fpcc_pkg::OutLow) begin
      result.fan_duty       = fpcc_pkg::LowDuty;
      result.cooling_active = 1'b1;
    end else if (ctl[fpcc_pkg::CtlW-1]) begin
      result.fan_duty       = ctl_neg[fpcc_pkg::DutyW-1:0];
      result.cooling_active = 1'b1;
    end else begin
      result.fan_duty       = fpcc_pkg::IdleDuty;
      result.cooling_active = 1'b0;
    end
  end

endmodule

// ===== sv/fan_pi_cooling_controller_unit.sv =====
// ----------------------------------------------------------------------------
// fan_pi_cooling_controller_unit: PI fan controller with integral clamp
// Turns temperature samples into fan duty commands in exact fixed point.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   in_*     slave      tdata[7:0] target_temp, tdata[19:8] measured_temp
//   out_*    master     tdata[9:0] fan_duty, tuser cooling_active
//   cfg_*    write      index 0 proportional_gain, index 1 integral_gain
//
// One transaction is accepted per cycle when the pipeline is free to move, and
// each produces exactly one result transaction through stages 1, 2 and 3. The
// integral update is a single add and clamp, so the running sum is ready for
// the next sample in the following cycle. Two more stages hold the gain
// products and the shaped output. rst_n is synchronous and active low; it
// resets the gains and the integral sum and empties the pipeline. A stall on
// out_tready holds the output register and backs up through the stages.
module fan_pi_cooling_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input samples.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] target_temp, [19:8] measured_temp, rest zero
  // Fan commands.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] fan_duty, rest zero
  output logic        out_tuser,  // [0] cooling_active
  // Gain registers.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [fpcc_pkg::GainW-1:0] prop_gain_r;
  logic [fpcc_pkg::GainW-1:0] int_gain_r;

  // Integral state, updated as each sample is accepted.
  logic signed [fpcc_pkg::SumW-1:0] sum_r;
  logic signed [fpcc_pkg::SumW-1:0] sum_nxt;

  logic [fpcc_pkg::TargetW-1:0]      target;
  logic signed [fpcc_pkg::MeasW-1:0] measured;
  logic signed [fpcc_pkg::ErrW-1:0]  err;
  logic signed [fpcc_pkg::SumW:0]    sum_add;

  // Stage 1: error and updated sum.
  logic                              s1_valid_r;
  logic signed [fpcc_pkg::ErrW-1:0]  s1_err_r;
  logic signed [fpcc_pkg::SumW-1:0]  s1_sum_r;
  // Stage 2: gain products.
  logic                                 s2_valid_r;
  logic signed [fpcc_pkg::PropProdW-1:0] s2_prop_r;
  logic signed [fpcc_pkg::IntProdW-1:0]  s2_int_r;
  // Stage 3: output register.
  logic              out_valid_r;
  fpcc_pkg::result_t out_r;
  fpcc_pkg::result_t shaped;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic in_fire;

  assign s3_ready  = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && in_tready;

  assign target   = in_tdata[7:0];
  assign measured = $signed(in_tdata[19:8]);

  // Error = 16 * target - measured; both fit in 14 signed bits.
  assign err = $signed({2'b00, target, 4'b0000}) - fpcc_pkg::ErrW'(measured);
  assign sum_add = (fpcc_pkg::SumW+1)'(sum_r) + (fpcc_pkg::SumW+1)'(err);

  always_comb begin
    if (!err[fpcc_pkg::ErrW-1]) begin
      // A non-negative error discards the wind-up and parks the sum at -50 degrees.
      sum_nxt = fpcc_pkg::SumForced;
    end else if (sum_add >= (fpcc_pkg::SumW+1)'(fpcc_pkg::SumMax)) begin
      sum_nxt = fpcc_pkg::SumMax;
    end else if (sum_add <= (fpcc_pkg::SumW+1)'(fpcc_pkg::SumMin)) begin
      sum_nxt = fpcc_pkg::SumMin;
    end else begin
      sum_nxt = sum_add[fpcc_pkg::SumW-1:0];
    end
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= fpcc_pkg::PropGainReset;
      int_gain_r  <= fpcc_pkg::IntGainReset;
      sum_r       <= fpcc_pkg::SumReset;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fpcc_pkg::CfgPropGain: prop_gain_r <= cfg_data;
          fpcc_pkg::CfgIntGain:  int_gain_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) sum_r <= sum_nxt;
      if (s1_ready) s1_valid_r  <= in_fire;
      if (s2_ready) s2_valid_r  <= s1_valid_r;
      if (s3_ready) out_valid_r <= s2_valid_r;
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_err_r <= err;
      s1_sum_r <= sum_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_prop_r <= fpcc_pkg::PropProdW'($signed({1'b0, prop_gain_r}))
                 * fpcc_pkg::PropProdW'(s1_err_r);
      s2_int_r  <= fpcc_pkg::IntProdW'($signed({1'b0, int_gain_r}))
                 * fpcc_pkg::IntProdW'(s1_sum_r);
    end
    if (s3_ready && s2_valid_r) begin
      out_r <= shaped;
    end
  end

  fpcc_shape u_shape (
    .prop_prod (s2_prop_r),
    .int_prod  (s2_int_r),
    .result    (shaped)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_r.fan_duty};
  assign out_tuser  = out_r.cooling_active;

  // The integral never leaves its clamp range.
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_r <= fpcc_pkg::SumMax) && (sum_r >= fpcc_pkg::SumMin))
    else $error("integral sum out of range");

  // A non-negative error parks the integral at the forced value.
  a_sum_forced: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !err[fpcc_pkg::ErrW-1]) |=> (sum_r == fpcc_pkg::SumForced))
    else $error("integral not forced after non-negative error");

  // Cooling commands carry a duty between 1 and 999; idle commands carry the idle duty.
  a_duty_cool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_r.fan_duty != 10'd0) && (out_r.fan_duty < 10'd1000))
    else $error("cooling duty out of range");

  a_duty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_r.fan_duty == fpcc_pkg::IdleDuty))
    else $error("idle duty wrong");

endmodule

// ===== dv/fan_pi_cooling_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fan_pi_cooling_controller_unit_tb: self-checking bench for the PI fan unit
// Streams temperature samples through the unit under several gain settings.
// Each fan command is checked against an independent prediction of the
// controller, with random gaps and stalls on both sides of the unit.
// ----------------------------------------------------------------------------
module fan_pi_cooling_controller_unit_tb;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 400;
  localparam int NumPhases  = 10;
  localparam int PhaseItems = 163;

  // Predicts the fan command for every accepted sample and holds the
  // commands that are still owed by the unit, oldest first.
  class fan_command_tracker;
    logic [fpcc_pkg::GainW-1:0] prop_gain;
    logic [fpcc_pkg::GainW-1:0] int_gain;
    int                         integral_sum;
    fpcc_pkg::result_t          expected_cmds[$];
    int                         mismatches;

    function new();
      prop_gain    = fpcc_pkg::PropGainReset;
      int_gain     = fpcc_pkg::IntGainReset;
      integral_sum = int'(fpcc_pkg::SumReset);
      mismatches   = 0;
    endfunction

    function void set_gain(logic idx, logic [fpcc_pkg::GainW-1:0] val);
      if (idx == fpcc_pkg::CfgPropGain) begin
        prop_gain = val;
      end else begin
        int_gain = val;
      end
    endfunction

    // One accepted sample: update the integral and queue the fan command.
    function void note_sample(logic [fpcc_pkg::TargetW-1:0] tgt,
                              logic [fpcc_pkg::MeasW-1:0] meas);
      int                err;
      int                sum;
      int                acc;
      int                ctl;
      fpcc_pkg::result_t cmd;
      err = int'(tgt) * 16 - int'($signed(meas));
      sum = integral_sum + err;
      // Once the room is at or below target the integral restarts at -50 degrees.
      if (err >= 0) sum = int'(fpcc_pkg::SumForced);
      if (sum >= int'(fpcc_pkg::SumMax)) sum = int'(fpcc_pkg::SumMax);
      if (sum <= int'(fpcc_pkg::SumMin)) sum = int'(fpcc_pkg::SumMin);
      integral_sum = sum;
      acc = int'(prop_gain) * err + int'(int_gain) * sum;
      // Integer division in SystemVerilog truncates toward zero.
      ctl = acc / 16;
      if (ctl >= int'(fpcc_pkg::OutMax)) ctl = int'(fpcc_pkg::OutMax);
      if (ctl <= int'(fpcc_pkg::OutLow)) ctl = -int'(fpcc_pkg::LowDuty);
      if (ctl < 0) begin
        cmd.fan_duty       = fpcc_pkg::DutyW'(-ctl);
        cmd.cooling_active = 1'b1;
      end else begin
        cmd.fan_duty       = fpcc_pkg::IdleDuty;
        cmd.cooling_active = 1'b0;
      end
      expected_cmds.push_back(cmd);
    endfunction

    // Every mismatch prints one line and is counted.
    task flag_mismatch(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    task check_command(logic [15:0] data, logic user);
      fpcc_pkg::result_t cmd;
      logic [15:0]       want;
      if (expected_cmds.size() == 0) begin
        flag_mismatch($sformatf("fan command %h/%b with no sample pending", data, user));
      end else begin
        cmd  = expected_cmds.pop_front();
        want = {{(16-fpcc_pkg::DutyW){1'b0}}, cmd.fan_duty};
        if (data !== want)
          flag_mismatch($sformatf("fan_duty: got %h, expected %h", data, want));
        if (user !== cmd.cooling_active)
          flag_mismatch($sformatf("cooling_active: got %b, expected %b",
                                  user, cmd.cooling_active));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] target_temp, [19:8] measured_temp, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [9:0] fan_duty, rest zero
  logic        out_tuser;  // [0] cooling_active
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  fan_command_tracker sb;

  // Idling controls, changed per phase by the main sequence.
  bit src_gaps;
  bit sink_stalls;
  bit long_hold_req;

  // Random samples come in runs around one target temperature, so that the
  // integral has time to wind down and reach its lower limit.
  int run_target;
  int run_left;
  int cycle_count;

  fan_pi_cooling_controller_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap lengths are mostly short, with the occasional long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Both channels are sampled at the rising edge; inputs only move at the
  // falling edge, so the values seen here are stable.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata[7:0], in_tdata[19:8]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_command(out_tdata, out_tuser);
  end

  // A hung unit ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("fan_pi_cooling_controller_unit: mismatch");
      $finish;
    end
  end

  // Result side. A long hold-off is counted here in cycles while the sender
  // keeps offering samples, so the pipeline fills and in_tready drops.
  initial begin : fan_cmd_sink
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready = 1'b0;
        for (int k = 0; k < LongHold; k++) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Offers one sample and returns at the rising edge where the transaction
  // is accepted. With no gap, tvalid simply stays high for the next sample.
  task automatic send_sample(input logic [7:0] tgt, input logic [11:0] meas);
    int gap;
    gap = (src_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0000, meas, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering samples and waits until every owed command has arrived.
  // Each sample yields a command, so an empty queue means an idle unit.
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gain(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.set_gain(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic next_sample(output logic [7:0] tgt, output logic [11:0] meas);
    int kind;
    int m;
    if (run_left == 0) begin
      run_target = $urandom_range(0, 127);
      run_left   = $urandom_range(4, 40);
    end
    run_left--;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      // Unconstrained noise, covering every code of both fields.
      tgt  = 8'($urandom);
      meas = 12'($urandom);
    end else begin
      if (kind < 11) m = run_target * 16 + int'($urandom_range(0, 60)) - 48;
      else if (kind < 16) m = run_target * 16 - int'($urandom_range(1, 700));
      else m = run_target * 16 + int'($urandom_range(0, 500));
      if (m > 2047) m = 2047;
      if (m < -2048) m = -2048;
      tgt  = 8'(run_target);
      meas = m[11:0];
    end
  endtask

  // Directed samples under the reset gains (proportional 30, integral 1).
  task automatic run_directed();
    send_sample(8'd20, 12'd336);     // small overshoot, integral from reset
    send_sample(8'd0, 12'h7ff);      // hottest reading, largest negative error
    send_sample(8'd0, 12'h7ff);
    send_sample(8'd0, 12'd2000);     // integral winds down to its lower limit and is pinned there
    send_sample(8'd0, 12'd2000);
    send_sample(8'd255, 12'h800);    // coldest reading, output saturates high
    send_sample(8'd35, 12'd0);       // output lands exactly on the upper limit
    send_sample(8'd2, 12'd5);        // output truncates to zero, fan idles
    send_sample(8'd2, 12'd6);        // output of minus one
    send_sample(8'd10, 12'd160);     // zero error forces the integral
    send_sample(8'd255, 12'h7ff);
    send_sample(8'd0, 12'hc90);      // reading of -880 sixteenths, that is -55 degrees
    send_sample(8'd125, 12'd2000);
    send_sample(8'd100, 12'd1601);   // error of minus one, integral winds down
    send_sample(8'd100, 12'd1601);
    send_sample(8'd100, 12'd1601);
    send_sample(8'd0, 12'hfff);      // reading of minus one sixteenth
    send_sample(8'haa, 12'h555);
    send_sample(8'h55, 12'haaa);
    send_sample(8'd0, 12'd400);      // mid-range cooling commands
    send_sample(8'd30, 12'd600);
    send_sample(8'd40, 12'd700);
  endtask

  initial begin : main_seq
    logic [7:0]  tgt;
    logic [11:0] meas;
    logic [7:0]  pgain [NumPhases];
    logic [7:0]  igain [NumPhases];
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_index     = fpcc_pkg::CfgPropGain;
    cfg_data      = '0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    long_hold_req = 1'b0;
    run_left      = 0;
    cycle_count   = 0;

    // Gain settings per phase: the extremes first, then random ones.
    pgain = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd1, 8'd30, 8'd0, 8'd0, 8'd0};
    igain = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0};
    for (int p = 7; p < NumPhases; p++) begin
      pgain[p] = 8'($urandom);
      igain[p] = 8'($urandom);
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    drain_outputs();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_gain(fpcc_pkg::CfgPropGain, pgain[ph]);
      write_gain(fpcc_pkg::CfgIntGain, igain[ph]);
      // Some phases run back to back on both sides, others with idling.
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      if (ph == 3) begin
        // The receiver holds off while samples keep coming with no gaps.
        src_gaps      = 1'b0;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        // Halfway through odd phases the sender waits for a fully drained unit.
        if (ph % 2 == 1 && i == PhaseItems / 2) drain_outputs();
        next_sample(tgt, meas);
        send_sample(tgt, meas);
      end
      drain_outputs();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("fan_pi_cooling_controller_unit: match");
    end else begin
      $display("fan_pi_cooling_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
